/* hw/rtl/lpfc_pkg.sv */
// Shared types and sizing constants for the LRU page fault counter.
// No dependencies; every other file imports this package.
package lpfc_pkg;

  localparam int NUM_FRAMES = 16;
  localparam int PAGE_W     = 16;
  localparam int CNT_W      = $clog2(NUM_FRAMES + 1);
  localparam int IDX_W      = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CAP_W      = 5;
  localparam int FAULT_W    = 32;

  // Broadcast control from the top level to every cell of the chain.
  typedef struct packed {
    logic              en;        // an item is accepted this cycle
    logic              evict;     // the oldest page leaves; the whole list shifts
    logic [CNT_W-1:0]  count;     // resident count after an optional clear
    logic [CNT_W-1:0]  load_pos;  // position that receives the referenced page
    logic [PAGE_W-1:0] page;      // referenced page
  } lpfc_ctrl_t;

endpackage

/* hw/rtl/lpfc_cell.sv */
// One frame of the recency list: holds a page, compares it against the reference
// and shifts toward the oldest end. Depends on lpfc_pkg.
module lpfc_cell
  import lpfc_pkg::*;
(
  input  logic              clk,
  input  logic [IDX_W-1:0]  idx,        // fixed position of this cell
  input  lpfc_ctrl_t        ctrl,
  input  logic              match_in,   // a match was found in an older cell
  output logic              match_out,  // a match at this cell or an older one
  input  logic [PAGE_W-1:0] nbr_page,   // page of the next newer cell
  output logic [PAGE_W-1:0] page_out
);

  logic [PAGE_W-1:0] page;
  logic [CNT_W-1:0]  pos;
  logic              occupied;
  logic              shift;

  assign pos       = CNT_W'(idx);
  assign occupied  = pos < ctrl.count;
  assign match_out = match_in | (occupied && (page == ctrl.page));
  assign shift     = ctrl.evict | match_out;
  assign page_out  = page;

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      if (pos == ctrl.load_pos) begin
        page <= ctrl.page;
      end else if (shift && (pos < ctrl.load_pos)) begin
        page <= nbr_page;
      end
    end
  end

endmodule

/* hw/rtl/lru_page_fault_counter.sv */
// Top level of the LRU page fault counter: a chain of lpfc_cell frames plus
// count, fault counter and output register. Depends on lpfc_pkg and lpfc_cell.
//
// Usage:
//   Input items arrive on s_axis: tdata carries page_number, tuser carries
//   clear_first. When clear_first is set, the list and fault count are emptied
//   before the reference is handled.
//   Each accepted item yields exactly one result item on m_axis: the hit flag,
//   the evicted flag and page (zero when nothing left), and the saturating
//   fault total since the last clear.
//   The capacity register (1..16 frames) is written through cfg_we/cfg_wdata
//   while the block is idle. Zero acts as one and values above 16 act as 16.
// Timing:
//   The result is registered on the edge that accepts the item. One item per
//   cycle is sustained while the receiver is ready. Each cell compares its page
//   in parallel, and a match ripples down the chain to select which cells shift.
// Reset:
//   rst clears the resident count, the fault count and the output valid, and
//   sets the capacity to 16. Frame contents are not cleared, because a frame is
//   read only once the count covers it.
// Stalls:
//   While a result waits on m_axis with tready low, s_axis_tready is low. The
//   input is taken again in the same cycle that the result leaves.
module lru_page_fault_counter
  import lpfc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [4:0]   cfg_wdata,      // capacity
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,   // [15:0] page_number
  input  logic         s_axis_tuser,   // [0] clear_first
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [55:0]  m_axis_tdata    // [0] hit, [1] evicted_valid,
                                       // [17:2] evicted_page, [49:18] fault_total,
                                       // [55:50] zero
);

  logic [CAP_W-1:0]   capacity;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [FAULT_W-1:0] faults;
  logic [FAULT_W-1:0] faults_next;

  logic [CNT_W-1:0]   eff_cap;
  logic [CNT_W-1:0]   eff_count;
  logic [FAULT_W-1:0] eff_faults;
  logic               accept;
  logic               hit;
  logic               evict;
  lpfc_ctrl_t         ctrl;

  logic [NUM_FRAMES:0]  match_chain;
  logic [PAGE_W-1:0]    cell_page [NUM_FRAMES];

  // Result register.
  logic                 res_hit;
  logic                 res_ev_valid;
  logic [PAGE_W-1:0]    res_ev_page;
  logic [FAULT_W-1:0]   res_faults;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Capacity zero acts as one; values above the frame count saturate.
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CNT_W'(1);
    end else if (CNT_W'(capacity) > CNT_W'(NUM_FRAMES)) begin
      eff_cap = CNT_W'(NUM_FRAMES);
    end else begin
      eff_cap = CNT_W'(capacity);
    end
  end

  // A clear empties the list before the reference is looked up.
  assign eff_count  = s_axis_tuser ? '0 : count;
  assign eff_faults = s_axis_tuser ? '0 : faults;

  // The match chain needs no evict information, so evict can depend on hit.
  assign match_chain[0] = 1'b0;
  assign hit            = match_chain[NUM_FRAMES];
  assign evict          = !hit && (eff_count >= eff_cap) && (eff_count != '0);

  always_comb begin
    ctrl.en    = accept;
    ctrl.evict = evict;
    ctrl.count = eff_count;
    ctrl.page  = s_axis_tdata[PAGE_W-1:0];
    if (hit || evict) begin
      ctrl.load_pos = eff_count - CNT_W'(1);
      count_next    = eff_count;
    end else begin
      ctrl.load_pos = eff_count;
      count_next    = eff_count + CNT_W'(1);
    end
    if (!hit && (eff_faults != {FAULT_W{1'b1}})) begin
      faults_next = eff_faults + FAULT_W'(1);
    end else begin
      faults_next = eff_faults;
    end
  end

  for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
    logic [PAGE_W-1:0] nbr;
    if (i == NUM_FRAMES - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_page[i+1];
    end
    lpfc_cell u_cell (
      .clk       (clk),
      .idx       (IDX_W'(i)),
      .ctrl      (ctrl),
      .match_in  (match_chain[i]),
      .match_out (match_chain[i+1]),
      .nbr_page  (nbr),
      .page_out  (cell_page[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity      <= CAP_W'(NUM_FRAMES);
      count         <= '0;
      faults        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (accept) begin
        count         <= count_next;
        faults        <= faults_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_hit      <= hit;
      res_ev_valid <= evict;
      res_ev_page  <= evict ? cell_page[0] : '0;
      res_faults   <= faults_next;
    end
  end

  assign m_axis_tdata = {6'b0, res_faults, res_ev_page, res_ev_valid, res_hit};

  // The resident count never passes the number of frames.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(NUM_FRAMES))
    else $error("resident count above frame count");

  // An accepted item always leaves a result in the output register.
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_axis_tvalid)
    else $error("accepted item produced no result");

  // An eviction happens only on a fault.
  a_evict_on_miss: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1] |-> !m_axis_tdata[0])
    else $error("eviction reported on a hit");

  // A fault result always carries a nonzero fault total.
  a_fault_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> (m_axis_tdata[49:18] != '0))
    else $error("fault result with zero fault total");

endmodule

/* sim/lru_fault_predictor.sv */
// Checker for the LRU page fault counter: watches the capacity writes and both
// item channels, predicts every result and compares it. Depends on lpfc_pkg.
module lru_fault_predictor
  import lpfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CAP_W-1:0]  cfg_wdata,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [PAGE_W-1:0] s_axis_tdata,
  input  logic              s_axis_tuser,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [55:0]       m_axis_tdata,
  output int                pending_results,
  output int                mismatch_count
);

  // Room for the expected results; the block holds at most one in flight.
  localparam int OUTCOME_SLOTS = 8;

  typedef struct packed {
    logic               hit;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [FAULT_W-1:0] fault_total;
  } page_outcome_t;

  logic [PAGE_W-1:0]  frames [NUM_FRAMES];  // index 0 is the least recent page
  int                 resident;
  logic [FAULT_W-1:0] faults;
  logic [CAP_W-1:0]   capacity_reg;
  page_outcome_t      expected_outcomes [OUTCOME_SLOTS];
  int                 outcome_wr;
  int                 outcome_rd;

  // Applies one reference to the recency list and returns what the block should report.
  function automatic page_outcome_t lru_reference(logic [PAGE_W-1:0] page, logic clear);
    page_outcome_t o;
    int            pos;
    int            frames_in_use;
    o   = '0;
    pos = -1;
    frames_in_use = (capacity_reg == 0) ? 1 :
                    (capacity_reg > NUM_FRAMES) ? NUM_FRAMES : int'(capacity_reg);
    if (clear) begin
      resident = 0;
      faults   = '0;
    end
    for (int i = 0; i < resident; i++) begin
      if (pos < 0 && frames[i] == page) pos = i;
    end
    if (pos >= 0) begin
      o.hit = 1'b1;
      for (int i = pos; i < resident - 1; i++) frames[i] = frames[i + 1];
      frames[resident - 1] = page;
    end else begin
      if (faults != '1) faults = faults + 1'b1;
      if (resident >= frames_in_use) begin
        // The list may hold more pages than the capacity after it was lowered;
        // the count then stays where it is.
        o.evicted_valid = 1'b1;
        o.evicted_page  = frames[0];
        for (int i = 0; i < resident - 1; i++) frames[i] = frames[i + 1];
        frames[resident - 1] = page;
      end else begin
        frames[resident] = page;
        resident++;
      end
    end
    o.fault_total = faults;
    return o;
  endfunction

  task automatic report_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    page_outcome_t want;
    if (rst) begin
      resident     = 0;
      faults       = '0;
      capacity_reg = CAP_W'(NUM_FRAMES);
      outcome_wr   = 0;
      outcome_rd   = 0;
    end else begin
      if (cfg_we) capacity_reg = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) begin
        if (outcome_wr - outcome_rd >= OUTCOME_SLOTS) begin
          $error("more references in flight than the checker can hold");
          mismatch_count++;
        end
        expected_outcomes[outcome_wr % OUTCOME_SLOTS] =
          lru_reference(s_axis_tdata, s_axis_tuser);
        outcome_wr++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (outcome_wr == outcome_rd) begin
          $error("result item with no reference waiting: %h", m_axis_tdata);
          mismatch_count++;
        end else begin
          want = expected_outcomes[outcome_rd % OUTCOME_SLOTS];
          outcome_rd++;
          report_field("hit", 32'(want.hit), 32'(m_axis_tdata[0]));
          report_field("evicted_valid", 32'(want.evicted_valid), 32'(m_axis_tdata[1]));
          report_field("evicted_page", 32'(want.evicted_page), 32'(m_axis_tdata[17:2]));
          report_field("fault_total", want.fault_total, m_axis_tdata[49:18]);
          report_field("padding", 32'd0, 32'(m_axis_tdata[55:50]));
        end
      end
    end
    pending_results <= outcome_wr - outcome_rd;
  end

endmodule

/* sim/testbench.sv */
// Top of the simulation for the LRU page fault counter: clock, reset, stimulus,
// receiver stalls and verdict. Depends on lpfc_pkg, the block and lru_fault_predictor.
module testbench
  import lpfc_pkg::*;
();

  // A whole stall of the receiver plus ordinary gaps stays far below this.
  localparam int WATCHDOG_LIMIT = 3000;
  // The receiver holds off once after HOLD_AT results; HOLD_CYCLES sets the length of the hold.
  localparam int HOLD_CYCLES    = 200;
  localparam int HOLD_AT        = 300;
  localparam int PHASES         = 12;
  localparam int REFS_PER_PHASE = 86;

  logic              clk;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [CAP_W-1:0]  cfg_wdata = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [PAGE_W-1:0] s_axis_tdata = '0;
  logic              s_axis_tuser = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [55:0]       m_axis_tdata;

  int pending_results;
  int mismatch_count;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int results_taken = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int stall_cycles = 0;

  // Capacity of each random phase. Zero and the values above the frame count
  // are here on purpose, and going from 16 to 2 leaves a full list above capacity.
  int phase_caps [PHASES] = '{1, 4, 16, 2, 0, 8, 31, 3, 17, 12, 5, 16};

  lru_page_fault_counter dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  lru_fault_predictor predictor (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .pending_results (pending_results),
    .mismatch_count  (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one reference and returns at the edge that accepts it. Before the
  // item the sender may sit idle for a random number of cycles; valid is only
  // lowered when such a gap is taken, so back-to-back items keep it high.
  task automatic send_ref(input logic [PAGE_W-1:0] page, input logic clear);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= page;
    s_axis_tuser  <= clear;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Writes the capacity once the block is idle. The pending count from the
  // checker is registered, so the task lets it update before trusting it. Every
  // reference yields a result, so an empty queue means the block is idle.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // The receiver decides its ready on its own. Once, after a number of
  // results, it holds off long enough for the output register to fill and the
  // input side to stall while the sender keeps offering items.
  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) results_taken <= results_taken + 1;
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (!hold_done && results_taken == HOLD_AT) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_done     <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // The watchdog ends the run when no item moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [PAGE_W-1:0] pool_base;
    logic [PAGE_W-1:0] page;
    int                pool_span;
    int                pick;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset capacity of 16: the extreme pages, a clear
    // on an empty list, and hits that move a page to the most recent end.
    send_ref(16'h0000, 1'b1);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'h0000, 1'b0);
    send_ref(16'hA5A5, 1'b0);
    send_ref(16'h5A5A, 1'b0);
    send_ref(16'hFFFF, 1'b0);

    // Capacity two while four pages are resident: misses evict the oldest
    // page without shrinking the list, and a clear starts a new trace.
    write_capacity(5'd2);
    send_ref(16'h1234, 1'b0);
    send_ref(16'h5A5A, 1'b0);
    send_ref(16'h8000, 1'b0);
    send_ref(16'h0001, 1'b1);
    send_ref(16'h0002, 1'b0);
    send_ref(16'h0001, 1'b0);
    send_ref(16'h0003, 1'b0);
    send_ref(16'h0003, 1'b1);

    // Capacity zero acts as one frame.
    write_capacity(5'd0);
    send_ref(16'h0007, 1'b0);
    send_ref(16'h0007, 1'b0);
    send_ref(16'h0008, 1'b0);

    // Capacity above the frame count acts as the full frame count.
    write_capacity(5'd31);
    send_ref(16'h7FFF, 1'b0);
    send_ref(16'h0008, 1'b0);

    // Random part. Most references come from a small pool around a random
    // base so that hits, misses and evictions all happen; the rest are the
    // extreme pages or any page at all. A clear now and then restarts a trace.
    for (int ph = 0; ph < PHASES; ph++) begin
      write_capacity(CAP_W'(phase_caps[ph]));
      if (ph < 4) begin
        send_idle_pct = 27;
        recv_idle_pct <= 81;
      end else if (ph < 8) begin
        send_idle_pct = 81;
        recv_idle_pct <= 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      pool_base = PAGE_W'($urandom_range(0, 65535));
      pool_span = (phase_caps[ph] > NUM_FRAMES) ? NUM_FRAMES + 4 : phase_caps[ph] + 5;
      for (int n = 0; n < REFS_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        if (pick < 75)
          page = pool_base ^ PAGE_W'($urandom_range(0, pool_span));
        else if (pick < 85)
          page = ($urandom_range(1) != 0) ? '1 : '0;
        else
          page = PAGE_W'($urandom);
        send_ref(page, $urandom_range(99) < 3);
      end
    end

    // Drain: wait until every result has arrived, then a few more cycles so
    // that a stray extra result would still be caught.
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* lru_page_fault_counter.f */
hw/rtl/lpfc_pkg.sv
hw/rtl/lpfc_cell.sv
hw/rtl/lru_page_fault_counter.sv
sim/lru_fault_predictor.sv
sim/testbench.sv
